// ===== rtl/sosc_pkg.sv =====
// Shared types and constants for the segmented odd prime sieve counter.
// Used by the front, back and top-level modules.
`default_nettype none
package sosc_pkg;

    localparam int PC_W    = 11;
    localparam int PI_W    = 10;
    localparam int TOTAL_W = 21;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_PROCESS_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROCESS_INDEX = 2'd1;

    // Request control word passed from front to back
    typedef struct packed {
        logic [PC_W-1:0] pc;
        logic [PI_W-1:0] pi;
        logic            trivial;
        logic            trivial_one;
    } req_ctrl_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQRT,
        ST_BCLR,
        ST_BRD,
        ST_BCHK,
        ST_BSQ,
        ST_BSTRIKE,
        ST_DIVC,
        ST_RANGE,
        ST_HIGH,
        ST_SEG,
        ST_SCLR,
        ST_PRD,
        ST_PSQ,
        ST_PCHK,
        ST_PDIV,
        ST_PFIX,
        ST_PJ,
        ST_STRIKE,
        ST_CNT,
        ST_FIN,
        ST_DONE
    } back_state_t;

endpackage
`default_nettype wire

// ===== rtl/sosc_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on nothing but its width parameter.
`default_nettype none
module sosc_div #(
    parameter int W = 26
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [W-1:0] dividend,
    input  wire logic [W-1:0] divisor,
    output logic              done,
    output logic [W-1:0]      quotient,
    output logic [W-1:0]      remainder
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  dsr_reg, dsr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    trial;

    // Shift in one dividend bit and try the subtract
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[W-1]};
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = W'(trial - {1'b0, dsr_reg});
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;
endmodule
`default_nettype wire

// ===== rtl/sosc_front.sv =====
// Front end: configuration registers, request classification and a
// two-word request queue. Depends on sosc_pkg.
`default_nettype none
module sosc_front #(
    parameter int LIMIT_BITS = 24
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            push,
    output logic                                 full,
    input  wire logic [LIMIT_BITS-1:0]           upper_limit,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [sosc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [sosc_pkg::PC_W-1:0]       cfg_data,
    output logic                                 req_valid,
    output sosc_pkg::req_ctrl_t                  req_ctrl,
    output logic [LIMIT_BITS-1:0]                req_limit,
    input  wire logic                            req_take
);
    import sosc_pkg::*;

    logic [PC_W-1:0]       pc_reg;
    logic [PI_W-1:0]       pi_reg;
    req_ctrl_t             q_ctrl_reg [2];
    logic [LIMIT_BITS-1:0] q_lim_reg [2];
    logic                  wp_reg, rp_reg;
    logic [1:0]            cnt_reg;
    req_ctrl_t             cls;
    logic                  do_push;

    assign cfg_ready = 1'b1;
    assign full      = (cnt_reg == 2'd2);
    assign do_push   = push && !full;

    // Classify: share outside split and small limits need no sieve
    always_comb
    begin
        cls.pc          = pc_reg;
        cls.pi          = pi_reg;
        cls.trivial     = ({1'b0, pi_reg} >= pc_reg) || (upper_limit < LIMIT_BITS'(3));
        cls.trivial_one = ({1'b0, pi_reg} < pc_reg) && (pi_reg == '0)
                          && (upper_limit == LIMIT_BITS'(2));
    end

    // Hold configuration words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= PC_W'(1);
            pi_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_PROCESS_COUNT: pc_reg <= cfg_data;
                REG_PROCESS_INDEX: pi_reg <= cfg_data[PI_W-1:0];
                default: ;
            endcase
        end
    end

    // Advance queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_push)
                wp_reg <= !wp_reg;
            if (req_take)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, do_push} - {1'b0, req_take};
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_ctrl_reg[wp_reg] <= cls;
            q_lim_reg[wp_reg]  <= upper_limit;
        end
    end

    assign req_valid = (cnt_reg != 2'd0);
    assign req_ctrl  = q_ctrl_reg[rp_reg];
    assign req_limit = q_lim_reg[rp_reg];
endmodule
`default_nettype wire

// ===== rtl/sosc_back.sv =====
// Back end: base prime sieve, segmented striking and counting, result word.
// Depends on sosc_pkg and sosc_div.
`default_nettype none
module sosc_back #(
    parameter int LIMIT_BITS       = 24,
    parameter int SEGMENT_LEN      = 32768,
    parameter int BASE_PRIME_DEPTH = 1024
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    input  wire sosc_pkg::req_ctrl_t           req_ctrl,
    input  wire logic [LIMIT_BITS-1:0]         req_limit,
    output logic                               req_take,
    output logic                               empty,
    input  wire logic                          pop,
    output logic [sosc_pkg::TOTAL_W-1:0]       prime_total
);
    import sosc_pkg::*;

    localparam int LB  = LIMIT_BITS;
    localparam int SB  = (LB + 1) / 2;
    localparam int MB  = SB - 1;
    localparam int MAP_DEPTH = 1 << MB;
    localparam int DW  = LB + 2;
    localparam int BPW = SB + 1;
    localparam int PPW = 2 * BPW;
    localparam int KW  = $clog2(BASE_PRIME_DEPTH);
    localparam int NW  = $clog2(BASE_PRIME_DEPTH + 1);
    localparam int SW  = $clog2(SEGMENT_LEN);
    localparam int QW  = $clog2(SB);

    back_state_t      state_reg, state_next;
    logic [LB-1:0]    n_reg, n_next;
    logic [PC_W-1:0]  pc_reg, pc_next;
    logic [PI_W-1:0]  pi_reg, pi_next;
    logic [SB-1:0]    r_reg, r_next;
    logic [QW-1:0]    sqb_reg, sqb_next;
    logic [MB-1:0]    m_reg, m_next;
    logic [MB-1:0]    i_reg, i_next;
    logic [BPW-1:0]   bp_reg, bp_next;
    logic [PPW-1:0]   pp_reg, pp_next;
    logic [PPW-1:0]   bj_reg, bj_next;
    logic [NW-1:0]    nb_reg, nb_next;
    logic [KW-1:0]    k_reg, k_next;
    logic [DW-1:0]    nodd_reg, nodd_next;
    logic [DW-1:0]    chunk_reg, chunk_next;
    logic [DW-1:0]    low_reg, low_next;
    logic [DW-1:0]    high_reg, high_next;
    logic [DW-1:0]    lo_reg, lo_next;
    logic [DW-1:0]    hi_reg, hi_next;
    logic [DW-1:0]    len_reg, len_next;
    logic [DW-1:0]    v_reg, v_next;
    logic [SB-1:0]    p_reg, p_next;
    logic [DW-1:0]    first_reg, first_next;
    logic [DW-1:0]    jj_reg, jj_next;
    logic             pend_reg, pend_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [TOTAL_W-1:0] res_reg, res_next;
    logic             res_valid_reg, res_valid_next;

    logic             map_mem [MAP_DEPTH];
    logic [SB-1:0]    list_mem [BASE_PRIME_DEPTH];
    logic             mark_mem [SEGMENT_LEN];
    logic             map_q, mark_q;
    logic [SB-1:0]    list_q;
    logic             map_we, map_wd, list_we, mark_we, mark_wd;
    logic [MB-1:0]    map_wa;

    logic             div_start, div_done;
    logic [DW-1:0]    div_a, div_b, div_q, div_r;

    logic [SB-1:0]    t_val;
    logic [2*SB-1:0]  t_sq;
    logic [DW-1:0]    seg_end, hsum, v_rem;
    logic [2*SB-1:0]  seg_pp;

    sosc_div #(.W(DW)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign t_val   = r_reg | (SB'(1) << sqb_reg);
    assign t_sq    = t_val * t_val;
    assign seg_pp  = p_reg * p_reg;
    assign seg_end = lo_reg + DW'(SEGMENT_LEN - 1);
    assign hsum    = low_reg + chunk_reg - DW'(1);
    assign v_rem   = v_reg + DW'(p_reg) - div_r;

    // Next state and datapath
    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        pc_next        = pc_reg;
        pi_next        = pi_reg;
        r_next         = r_reg;
        sqb_next       = sqb_reg;
        m_next         = m_reg;
        i_next         = i_reg;
        bp_next        = bp_reg;
        pp_next        = pp_reg;
        bj_next        = bj_reg;
        nb_next        = nb_reg;
        k_next         = k_reg;
        nodd_next      = nodd_reg;
        chunk_next     = chunk_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        len_next       = len_reg;
        v_next         = v_reg;
        p_next         = p_reg;
        first_next     = first_reg;
        jj_next        = jj_reg;
        pend_next      = 1'b0;
        total_next     = total_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        req_take       = 1'b0;
        map_we         = 1'b0;
        map_wd         = 1'b0;
        map_wa         = i_reg;
        list_we        = 1'b0;
        mark_we        = 1'b0;
        mark_wd        = 1'b0;
        div_start      = 1'b0;
        div_a          = v_reg;
        div_b          = DW'(p_reg);

        // Drop the result word once popped
        if (pop && res_valid_reg)
            res_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_take  = 1'b1;
                    n_next    = req_limit;
                    pc_next   = req_ctrl.pc;
                    pi_next   = req_ctrl.pi;
                    r_next    = '0;
                    sqb_next  = QW'(SB - 1);
                    nb_next   = '0;
                    nodd_next = DW'((req_limit - LB'(1)) >> 1);
                    if (req_ctrl.trivial)
                    begin
                        total_next = TOTAL_W'(req_ctrl.trivial_one);
                        state_next = ST_DONE;
                    end
                    else
                        state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                if (t_sq <= (2*SB)'(n_reg))
                    r_next = t_val;
                if (sqb_reg == '0)
                begin
                    state_next = ST_BCLR;
                    i_next     = '0;
                end
                else
                    sqb_next = sqb_reg - 1'b1;
            end
            ST_BCLR:
            begin
                m_next = MB'((r_reg - SB'(1)) >> 1);
                map_we = 1'b1;
                map_wa = i_reg;
                if (i_reg == MB'((r_reg - SB'(1)) >> 1))
                begin
                    i_next     = '0;
                    state_next = ST_BRD;
                end
                else
                    i_next = i_reg + 1'b1;
            end
            ST_BRD:
                state_next = ST_BCHK;
            ST_BCHK:
            begin
                bp_next = BPW'({i_reg, 1'b0}) + BPW'(3);
                pp_next = (BPW'({i_reg, 1'b0}) + BPW'(3)) * (BPW'({i_reg, 1'b0}) + BPW'(3));
                if (map_q)
                begin
                    if (i_reg == m_reg)
                        state_next = ST_DIVC;
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = ST_BRD;
                    end
                end
                else
                    state_next = ST_BSQ;
            end
            ST_BSQ:
            begin
                bj_next = (pp_reg - PPW'(3)) >> 1;
                if (pp_reg <= PPW'(n_reg) && nb_reg < NW'(BASE_PRIME_DEPTH))
                begin
                    list_we = 1'b1;
                    nb_next = nb_reg + 1'b1;
                end
                state_next = ST_BSTRIKE;
            end
            ST_BSTRIKE:
            begin
                if (bj_reg <= PPW'(m_reg))
                begin
                    map_we  = 1'b1;
                    map_wd  = 1'b1;
                    map_wa  = bj_reg[MB-1:0];
                    bj_next = bj_reg + PPW'(bp_reg);
                end
                else if (i_reg == m_reg)
                    state_next = ST_DIVC;
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_BRD;
                end
            end
            ST_DIVC:
            begin
                // Start chunk division on entry, then wait for it
                if (div_done)
                begin
                    chunk_next = div_q;
                    state_next = ST_RANGE;
                end
                else if (!pend_reg)
                begin
                    div_start = 1'b1;
                    div_a     = nodd_reg + DW'(pc_reg) - DW'(1);
                    div_b     = DW'(pc_reg);
                end
                pend_next = 1'b1;
            end
            ST_RANGE:
            begin
                low_next   = DW'(pi_reg * chunk_reg);
                state_next = ST_HIGH;
            end
            ST_HIGH:
            begin
                total_next = '0;
                lo_next    = low_reg;
                if (hsum >= nodd_reg)
                    high_next = nodd_reg - DW'(1);
                else
                    high_next = hsum;
                if (low_reg > ((hsum >= nodd_reg) ? nodd_reg - DW'(1) : hsum))
                    state_next = ST_DONE;
                else
                    state_next = ST_SEG;
            end
            ST_SEG:
            begin
                hi_next    = (seg_end > high_reg) ? high_reg : seg_end;
                len_next   = ((seg_end > high_reg) ? high_reg : seg_end) - lo_reg + DW'(1);
                v_next     = {lo_reg[DW-2:0], 1'b0} + DW'(3);
                jj_next    = '0;
                k_next     = '0;
                state_next = ST_SCLR;
            end
            ST_SCLR:
            begin
                mark_we = 1'b1;
                if (jj_reg + DW'(1) == len_reg)
                begin
                    jj_next    = '0;
                    state_next = (nb_reg == '0) ? ST_CNT : ST_PRD;
                end
                else
                    jj_next = jj_reg + DW'(1);
            end
            ST_PRD:
                state_next = ST_PSQ;
            ST_PSQ:
            begin
                p_next     = list_q;
                state_next = ST_PCHK;
            end
            ST_PCHK:
            begin
                if (DW'(seg_pp) > v_reg)
                begin
                    first_next = DW'(seg_pp);
                    state_next = ST_PFIX;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_PDIV;
                end
            end
            ST_PDIV:
            begin
                if (div_done)
                begin
                    first_next = (div_r == '0) ? v_reg : v_rem;
                    state_next = ST_PFIX;
                end
            end
            ST_PFIX:
            begin
                if (!first_reg[0])
                    first_next = first_reg + DW'(p_reg);
                state_next = ST_PJ;
            end
            ST_PJ:
            begin
                jj_next    = (first_reg - v_reg) >> 1;
                state_next = ST_STRIKE;
            end
            ST_STRIKE:
            begin
                if (jj_reg < len_reg)
                begin
                    mark_we = 1'b1;
                    mark_wd = 1'b1;
                    jj_next = jj_reg + DW'(p_reg);
                end
                else if (NW'(k_reg) + NW'(1) == nb_reg)
                begin
                    jj_next    = '0;
                    state_next = ST_CNT;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_PRD;
                end
            end
            ST_CNT:
            begin
                // Issue reads below len, count unmarked words in the following cycle
                if (pend_reg && !mark_q)
                    total_next = total_reg + TOTAL_W'(1);
                if (jj_reg < len_reg)
                begin
                    pend_next = 1'b1;
                    jj_next   = jj_reg + DW'(1);
                end
                else if (!pend_reg)
                begin
                    if (hi_reg == high_reg)
                        state_next = ST_FIN;
                    else
                    begin
                        lo_next    = lo_reg + DW'(SEGMENT_LEN);
                        state_next = ST_SEG;
                    end
                end
            end
            ST_FIN:
            begin
                if (pi_reg == '0)
                    total_next = total_reg + TOTAL_W'(1);
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!res_valid_reg)
                begin
                    res_next       = total_reg;
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            total_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            pend_reg      <= pend_next;
            total_reg     <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        pc_reg    <= pc_next;
        pi_reg    <= pi_next;
        r_reg     <= r_next;
        sqb_reg   <= sqb_next;
        m_reg     <= m_next;
        i_reg     <= i_next;
        bp_reg    <= bp_next;
        pp_reg    <= pp_next;
        bj_reg    <= bj_next;
        nb_reg    <= nb_next;
        k_reg     <= k_next;
        nodd_reg  <= nodd_next;
        chunk_reg <= chunk_next;
        low_reg   <= low_next;
        high_reg  <= high_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        len_reg   <= len_next;
        v_reg     <= v_next;
        p_reg     <= p_next;
        first_reg <= first_next;
        jj_reg    <= jj_next;
        res_reg   <= res_next;
    end

    // Base composite map
    always_ff @(posedge clk)
    begin
        if (map_we)
            map_mem[map_wa] <= map_wd;
        map_q <= map_mem[i_reg];
    end

    // Base prime list
    always_ff @(posedge clk)
    begin
        if (list_we)
            list_mem[nb_reg[KW-1:0]] <= bp_reg[SB-1:0];
        list_q <= list_mem[k_reg];
    end

    // Segment marks
    always_ff @(posedge clk)
    begin
        if (mark_we)
            mark_mem[jj_reg[SW-1:0]] <= mark_wd;
        mark_q <= mark_mem[jj_reg[SW-1:0]];
    end

    assign empty       = !res_valid_reg;
    assign prime_total = res_reg;
endmodule
`default_nettype wire

// ===== rtl/segmented_odd_prime_sieve_count_core.sv =====
// Prime counter for one share of the odd numbers up to a limit.
// Queue-style request and result channels, write-only configuration port.
// A request is pushed while full is low. Up to two requests wait in the
// front queue while the back end works on another. The back end finds the
// base primes up to the integer square root of the limit, then walks the
// share in segments of SEGMENT_LEN odd numbers: clear, strike, count.
// A request that needs no sieve (limit below three or a share index
// outside the split) goes straight to its result word. One request is
// sieved at a time. The result word stays on prime_total while empty is
// low until popped; a finished total waits in the back end until the
// result register frees up, and no new request starts meanwhile.
// Reset sets process_count to 1 and process_index to 0 and empties queues.
// Configuration must be written only while idle; the block itself does
// not enforce this. cfg_ready is always high.
`default_nettype none
module segmented_odd_prime_sieve_count_core #(
    parameter int LIMIT_BITS       = 24,
    parameter int SEGMENT_LEN      = 32768,
    parameter int BASE_PRIME_DEPTH = 1024
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            push,
    output logic                                 full,
    input  wire logic [LIMIT_BITS-1:0]           upper_limit,
    output logic                                 empty,
    input  wire logic                            pop,
    output logic [sosc_pkg::TOTAL_W-1:0]         prime_total,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [sosc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [sosc_pkg::PC_W-1:0]       cfg_data
);
    import sosc_pkg::*;

    logic                  req_valid, req_take;
    req_ctrl_t             req_ctrl;
    logic [LIMIT_BITS-1:0] req_limit;

    sosc_front #(.LIMIT_BITS(LIMIT_BITS)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .upper_limit (upper_limit),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .req_valid   (req_valid),
        .req_ctrl    (req_ctrl),
        .req_limit   (req_limit),
        .req_take    (req_take)
    );

    sosc_back #(
        .LIMIT_BITS       (LIMIT_BITS),
        .SEGMENT_LEN      (SEGMENT_LEN),
        .BASE_PRIME_DEPTH (BASE_PRIME_DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ctrl    (req_ctrl),
        .req_limit   (req_limit),
        .req_take    (req_take),
        .empty       (empty),
        .pop         (pop),
        .prime_total (prime_total)
    );
endmodule
`default_nettype wire

// ===== tb/segmented_odd_prime_sieve_count_core_chk.sv =====
// Checker for the segmented odd prime sieve counter: tracks the split
// registers, predicts each share's prime total and compares popped words.
// Depends on sosc_pkg for the register indexes and port widths.
module segmented_odd_prime_sieve_count_core_chk
    import sosc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire logic                 full,
    input  wire logic [23:0]          upper_limit,
    input  wire logic                 empty,
    input  wire logic                 pop,
    input  wire logic [TOTAL_W-1:0]   prime_total,
    input  wire logic                 cfg_valid,
    input  wire logic                 cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [PC_W-1:0]      cfg_data,
    output int                        fails,
    output int                        pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SEG_LEN  = 32768;
    localparam int MAP_LEN  = 2048;
    localparam int LIST_LEN = 1024;

    logic [PC_W-1:0]    split_count;
    logic [PI_W-1:0]    split_index;
    logic [TOTAL_W-1:0] totals_due[$];

    bit                 odd_composite[MAP_LEN];
    int unsigned        sieve_primes[LIST_LEN];
    bit                 seg_struck[SEG_LEN];

    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 31; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if (t * t <= v)
                r = t;
        end
        return r;
    endfunction

    // Count primes in the current share of the odd numbers up to n
    function automatic logic [TOTAL_W-1:0] share_prime_total(longint unsigned n);
        longint unsigned pc, pi, s, m, p, j, n_odds, chunk, lo_idx, hi_idx;
        longint unsigned seg, seg_hi, len, v, first, rem;
        int                 nbase;
        logic [TOTAL_W-1:0] total;
        pc = split_count;
        pi = split_index;
        nbase = 0;
        total = '0;
        if (pi >= pc)
            return '0;
        if (n < 3)
            return (n == 2 && pi == 0) ? 1 : 0;
        s = isqrt(n);
        m = (s - 1) / 2;
        foreach (odd_composite[i])
            odd_composite[i] = 0;
        // collect base primes with a small odd-only sieve
        for (longint unsigned i = 0; i <= m && i < MAP_LEN; i++)
        begin
            if (!odd_composite[i])
            begin
                p = 2 * i + 3;
                for (j = (p * p - 3) / 2; j <= m && j < MAP_LEN; j += p)
                    odd_composite[j] = 1;
                if (p * p <= n && nbase < LIST_LEN)
                begin
                    sieve_primes[nbase] = p;
                    nbase++;
                end
            end
        end
        n_odds = (n - 1) / 2;
        chunk  = (n_odds + pc - 1) / pc;
        lo_idx = pi * chunk;
        hi_idx = (pi + 1) * chunk - 1;
        if (hi_idx >= n_odds)
            hi_idx = n_odds - 1;
        if (lo_idx > hi_idx)
            return '0;
        // strike and count segment by segment
        for (seg = lo_idx; seg <= hi_idx; seg += SEG_LEN)
        begin
            seg_hi = seg + SEG_LEN - 1;
            if (seg_hi > hi_idx)
                seg_hi = hi_idx;
            len = seg_hi - seg + 1;
            v = 2 * seg + 3;
            for (int k = 0; k < len; k++)
                seg_struck[k] = 0;
            for (int k = 0; k < nbase; k++)
            begin
                p = sieve_primes[k];
                if (p * p > v)
                    first = p * p;
                else
                begin
                    rem = v % p;
                    first = (rem == 0) ? v : v + (p - rem);
                end
                if (first[0] == 1'b0)
                    first += p;
                for (j = (first - v) / 2; j < len; j += p)
                    seg_struck[j] = 1;
            end
            for (int k = 0; k < len; k++)
                if (!seg_struck[k])
                    total = total + 1'b1;
        end
        if (pi == 0)
            total = total + 1'b1;
        return total;
    endfunction

    assign pending = totals_due.size();

    // Track split registers, queue predictions, compare popped words
    always @(posedge clk or negedge rst_n)
    begin
        logic [TOTAL_W-1:0] want;
        if (!rst_n)
        begin
            split_count <= 11'd1;
            split_index <= '0;
            fails       <= 0;
            totals_due.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_PROCESS_COUNT)
                    split_count <= cfg_data;
                else if (cfg_index == REG_PROCESS_INDEX)
                    split_index <= cfg_data[PI_W-1:0];
            end
            if (push && !full)
                totals_due.push_back(share_prime_total(upper_limit));
            if (pop && !empty)
            begin
                if (totals_due.size() == 0)
                begin
                    $error("prime_total: no word expected, actual %0d", prime_total);
                    fails <= fails + 1;
                end
                else
                begin
                    want = totals_due.pop_front();
                    if (prime_total !== want)
                    begin
                        $error("prime_total: expected %0d, actual %0d", want, prime_total);
                        fails <= fails + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== tb/segmented_odd_prime_sieve_count_core_tb.sv =====
// Top of the sieve counter testbench: clock, reset, request and result
// traffic, split register writes and the verdict.
// Depends on sosc_pkg, the core and segmented_odd_prime_sieve_count_core_chk.
module segmented_odd_prime_sieve_count_core_tb;
    import sosc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 20000000;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic                 clk = 0;
    logic                 rst_n = 0;
    logic                 push = 0;
    logic                 full;
    logic [23:0]          upper_limit = '0;
    logic                 empty;
    logic                 pop = 0;
    logic [TOTAL_W-1:0]   prime_total;
    logic                 cfg_valid = 0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [PC_W-1:0]      cfg_data = '0;
    int                   fails;
    int                   pending;
    int                   cycles = 0;
    int                   pop_gap = 0;
    bit                   no_idle = 0;
    bit                   hold_req = 0;
    bit                   hold = 0;

    segmented_odd_prime_sieve_count_core u_top (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .upper_limit(upper_limit), .empty(empty), .pop(pop),
        .prime_total(prime_total), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    segmented_odd_prime_sieve_count_core_chk u_chk (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .upper_limit(upper_limit), .empty(empty), .pop(pop),
        .prime_total(prime_total), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .fails(fails), .pending(pending)
    );

    always #5 clk = ~clk;

    // Abort on a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver: draw a gap per word, stall during a hold-off
    always @(negedge clk)
        pop <= (pop_gap == 0) && !hold;

    always @(posedge clk)
    begin
        if (pop && !empty)
            pop_gap <= no_idle ? 0 : $urandom_range(0, 7);
        else if (pop_gap > 0)
            pop_gap <= pop_gap - 1;
    end

    // Long receiver hold-off, counted here
    initial
    begin
        wait (hold_req);
        @(negedge clk);
        hold <= 1;
        repeat (3000) @(negedge clk);
        hold <= 0;
    end

    // Offer one word; returns at the accepting edge with push still high
    task automatic send_limit(input logic [23:0] n);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        @(negedge clk);
        if (gap != 0)
        begin
            push <= 0;
            repeat (gap) @(negedge clk);
        end
        push <= 1;
        upper_limit <= n;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PC_W-1:0] d);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 0;
        @(negedge clk);
    endtask

    // Stop offering, then hold until every expected word has been popped
    task automatic drain();
        @(negedge clk);
        push <= 0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic set_split(input int pc, input int pi);
        drain();
        write_reg(REG_PROCESS_COUNT, PC_W'(pc));
        write_reg(REG_PROCESS_INDEX, PC_W'(pi));
    endtask

    function automatic logic [23:0] rand_limit();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 24'($urandom_range(0, 3));
        else if (r < 88)
            return 24'($urandom_range(4, 4000));
        else
            return 24'($urandom_range(4001, 40000));
    endfunction

    initial
    begin
        int pc;
        int pi;
        repeat (6) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        // small limits and plain counts on the default split
        send_limit(0); send_limit(1); send_limit(2); send_limit(3);
        send_limit(4); send_limit(5); send_limit(9); send_limit(25);
        send_limit(1000);
        // share outside the split
        set_split(1, 1);
        send_limit(2); send_limit(100);
        // unused register index is ignored
        drain();
        write_reg(REG_UNUSED, 11'h7ff);
        set_split(2, 1);
        send_limit(2); send_limit(3); send_limit(1000);
        // last share of the split, empty for the small limit
        set_split(3, 2);
        send_limit(5); send_limit(1000);
        // largest limit on the widest split
        set_split(1024, 0);
        send_limit(24'hffffff); send_limit(2);
        set_split(1024, 1023);
        send_limit(24'hffffff);

        // fill the queue while the receiver holds off
        set_split(1, 0);
        hold_req = 1;
        for (int i = 0; i < 8; i++)
            send_limit(24'($urandom_range(0, 200)));
        drain();

        // random phases over varied splits
        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph == 4)
            begin
                pc = 1024;
                pi = $urandom_range(0, 1023);
            end
            else
            begin
                pc = $urandom_range(1, 8);
                pi = $urandom_range(0, pc);
            end
            set_split(pc, pi);
            no_idle = (ph == 1);
            for (int i = 0; i < 16; i++)
                send_limit(rand_limit());
            no_idle = 0;
        end

        drain();
        repeat (50) @(negedge clk);
        if (fails == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
